/* hdl/mrfe_pkg.sv */
`default_nettype none
package mrfe_pkg;

   localparam int REQUEST_LEN_DEF  = 64;
   localparam int RESPONSE_LEN_DEF = 256;

   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int RETRY_W    = 6;
   localparam int ID_W       = 24;
   localparam int CRC_W      = 16;
   localparam int HDR_LEN    = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   localparam logic [CRC_W-1:0]   CRC_POLY        = 16'hA001;
   localparam logic [ID_W-1:0]    READER_ID_RST   = 24'h123456;
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 6'd20;
   localparam logic [RETRY_W-1:0] RETRY_MAX       = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 3'd0,
      CMD_PAYLOAD = 3'd1,
      CMD_PULL    = 3'd2,
      CMD_RESP    = 3'd3,
      CMD_TIMEOUT = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACCEPT  = 3'd0,
      ST_TX      = 3'd1,
      ST_VALID   = 3'd2,
      ST_CRCBAD  = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_GAVEUP  = 3'd5,
      ST_ERROR   = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_READER_ID   = 1'b0,
      CSR_RETRY_LIMIT = 1'b1
   } csr_type;

   // request held in the input register
   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
   } req_stage_type;

   // CRC-16/ARC, reflected, one byte
   function automatic logic [CRC_W-1:0] crc_arc_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/mrfe_if.sv */
`default_nettype none
interface mrfe_req_if;
   logic                       valid;
   logic                       ready;
   logic [mrfe_pkg::CMD_W-1:0]  cmd;
   logic [mrfe_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface mrfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mrfe_pkg::STATUS_W-1:0] status;
   logic [mrfe_pkg::BYTE_W-1:0]   tx_byte;
   logic                         tx_last;
   logic [mrfe_pkg::RETRY_W-1:0]  retry_count;

   modport source (output valid, output status, output tx_byte, output tx_last,
                   output retry_count, input ready);
   modport sink   (input valid, input status, input tx_byte, input tx_last,
                   input retry_count, output ready);
endinterface
`default_nettype wire

/* hdl/mrfe_payload_ram.sv */
`default_nettype none
module mrfe_payload_ram #(
   parameter int DEPTH = mrfe_pkg::REQUEST_LEN_DEF - mrfe_pkg::HDR_LEN,
   parameter int AW    = $clog2(mrfe_pkg::REQUEST_LEN_DEF - mrfe_pkg::HDR_LEN)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [mrfe_pkg::BYTE_W-1:0] wr_data,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [mrfe_pkg::BYTE_W-1:0] rd_data
);

   localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

   logic [mrfe_pkg::BYTE_W-1:0] mem [DEPTH];
   logic [mrfe_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if ({1'b0, rd_addr} < DEPTH_W) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/mrfe_req_stage.sv */
`default_nettype none
module mrfe_req_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   mrfe_req_if.sink                    req,
   input  wire logic                   advance,
   output mrfe_pkg::req_stage_type     stage
);

   logic                        valid_ff, valid_in;
   logic [mrfe_pkg::CMD_W-1:0]  cmd_ff;
   logic [mrfe_pkg::BYTE_W-1:0] data_ff;
   logic                        take;

   // input register frees up in the same cycle its request moves on
   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         cmd_ff  <= req.cmd;
         data_ff <= req.data_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.cmd   = cmd_ff;
   assign stage.data  = data_ff;

endmodule
`default_nettype wire

/* hdl/mrfe_core.sv */
`default_nettype none
module mrfe_core #(
   parameter int REQUEST_LEN  = mrfe_pkg::REQUEST_LEN_DEF,
   parameter int RESPONSE_LEN = mrfe_pkg::RESPONSE_LEN_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_we,
   input  wire logic [mrfe_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire logic [mrfe_pkg::CSR_DATA_W-1:0]           csr_wdata,
   input  wire mrfe_pkg::req_stage_type                   stage,
   output logic                                           advance,
   output logic                                           ram_wr_en,
   output logic [$clog2(REQUEST_LEN-mrfe_pkg::HDR_LEN)-1:0] ram_wr_addr,
   output logic [mrfe_pkg::BYTE_W-1:0]                    ram_wr_data,
   output logic [$clog2(REQUEST_LEN-mrfe_pkg::HDR_LEN)-1:0] ram_rd_addr,
   input  wire logic [mrfe_pkg::BYTE_W-1:0]               ram_rd_data,
   mrfe_rsp_if.source                                     rsp
);

   localparam int PAY_DEPTH = REQUEST_LEN - mrfe_pkg::HDR_LEN;
   localparam int PAY_AW    = $clog2(PAY_DEPTH);
   localparam int PCNT_W    = $clog2(PAY_DEPTH + 1);
   localparam int TXP_W     = $clog2(REQUEST_LEN + 3);
   localparam int RXP_W     = $clog2(RESPONSE_LEN + 2);
   localparam int BW        = mrfe_pkg::BYTE_W;
   localparam int CW        = mrfe_pkg::CRC_W;
   localparam int RW        = mrfe_pkg::RETRY_W;

   localparam logic [PCNT_W-1:0] PAY_MAX   = PCNT_W'(PAY_DEPTH);
   localparam logic [TXP_W-1:0]  HDR       = TXP_W'(mrfe_pkg::HDR_LEN);
   localparam logic [TXP_W-1:0]  TX_CRC_LO = TXP_W'(REQUEST_LEN);
   localparam logic [TXP_W-1:0]  TX_END    = TXP_W'(REQUEST_LEN + 2);
   localparam logic [RXP_W-1:0]  RX_CRC_LO = RXP_W'(RESPONSE_LEN);

   // configuration
   logic [mrfe_pkg::ID_W-1:0] reader_id_ff;
   logic [RW-1:0]             retry_limit_ff;

   // exchange state
   logic [BW-1:0]             code_ff, code_in;
   logic [mrfe_pkg::ID_W-1:0] hdr_id_ff, hdr_id_in;
   logic [PCNT_W-1:0]         pcnt_ff, pcnt_in;
   logic [CW-1:0]             tx_crc_ff, tx_crc_in;
   logic [TXP_W-1:0]          tx_pos_ff, tx_pos_in;
   logic [CW-1:0]             rx_crc_ff, rx_crc_in;
   logic [RXP_W-1:0]          rx_pos_ff, rx_pos_in;
   logic [BW-1:0]             rx_low_ff, rx_low_in;
   logic [RW-1:0]             retries_ff, retries_in;
   logic                      done_ff, done_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   mrfe_pkg::status_type      status_ff, status_in;
   logic [BW-1:0]             tx_byte_ff, tx_byte_in;
   logic                      tx_last_ff, tx_last_in;
   logic [RW-1:0]             retry_count_ff;

   logic [BW-1:0]             frame_byte;
   logic                      give_up;
   logic                      do_fail;
   mrfe_pkg::status_type      fail_why;

   assign advance = stage.valid && (!rsp_valid_ff || rsp.ready);
   assign give_up = retries_ff >= retry_limit_ff;

   // frame byte at the current transmit position; payload beyond the fill count reads zero
   always_comb begin
      priority if (tx_pos_ff == TXP_W'(0)) begin
         frame_byte = code_ff;
      end else if (tx_pos_ff == TXP_W'(1)) begin
         frame_byte = hdr_id_ff[23:16];
      end else if (tx_pos_ff == TXP_W'(2)) begin
         frame_byte = hdr_id_ff[15:8];
      end else if (tx_pos_ff == TXP_W'(3)) begin
         frame_byte = hdr_id_ff[7:0];
      end else if (tx_pos_ff < (TXP_W'(pcnt_ff) + HDR)) begin
         frame_byte = ram_rd_data;
      end else begin
         frame_byte = '0;
      end
   end

   always_comb begin
      code_in    = code_ff;
      hdr_id_in  = hdr_id_ff;
      pcnt_in    = pcnt_ff;
      tx_crc_in  = tx_crc_ff;
      tx_pos_in  = tx_pos_ff;
      rx_crc_in  = rx_crc_ff;
      rx_pos_in  = rx_pos_ff;
      rx_low_in  = rx_low_ff;
      retries_in = retries_ff;
      done_in    = done_ff;
      status_in  = mrfe_pkg::ST_ERROR;
      tx_byte_in = '0;
      tx_last_in = 1'b0;
      ram_wr_en  = 1'b0;
      do_fail    = 1'b0;
      fail_why   = mrfe_pkg::ST_TIMEOUT;

      if (advance) begin
         unique case (mrfe_pkg::cmd_type'(stage.cmd))
            mrfe_pkg::CMD_START: begin
               code_in    = stage.data;
               hdr_id_in  = reader_id_ff;
               pcnt_in    = '0;
               retries_in = '0;
               done_in    = 1'b0;
               tx_pos_in  = '0;
               tx_crc_in  = '0;
               rx_pos_in  = '0;
               rx_crc_in  = '0;
               rx_low_in  = '0;
               status_in  = mrfe_pkg::ST_ACCEPT;
            end
            mrfe_pkg::CMD_PAYLOAD: begin
               if (!done_ff && tx_pos_ff == '0 && retries_ff == '0 && pcnt_ff < PAY_MAX) begin
                  ram_wr_en = 1'b1;
                  pcnt_in   = pcnt_ff + PCNT_W'(1);
                  status_in = mrfe_pkg::ST_ACCEPT;
               end
            end
            mrfe_pkg::CMD_PULL: begin
               if (!done_ff && tx_pos_ff < TX_END) begin
                  priority if (tx_pos_ff < TX_CRC_LO) begin
                     tx_byte_in = frame_byte;
                     tx_crc_in  = mrfe_pkg::crc_arc_byte(tx_crc_ff, frame_byte);
                  end else if (tx_pos_ff == TX_CRC_LO) begin
                     tx_byte_in = tx_crc_ff[7:0];
                  end else begin
                     tx_byte_in = tx_crc_ff[15:8];
                     tx_last_in = 1'b1;
                  end
                  tx_pos_in = tx_pos_ff + TXP_W'(1);
                  status_in = mrfe_pkg::ST_TX;
               end
            end
            mrfe_pkg::CMD_RESP: begin
               if (!done_ff && tx_pos_ff == TX_END) begin
                  priority if (rx_pos_ff < RX_CRC_LO) begin
                     rx_crc_in = mrfe_pkg::crc_arc_byte(rx_crc_ff, stage.data);
                     rx_pos_in = rx_pos_ff + RXP_W'(1);
                     status_in = mrfe_pkg::ST_ACCEPT;
                  end else if (rx_pos_ff == RX_CRC_LO) begin
                     rx_low_in = stage.data;
                     rx_pos_in = rx_pos_ff + RXP_W'(1);
                     status_in = mrfe_pkg::ST_ACCEPT;
                  end else if ({stage.data, rx_low_ff} == rx_crc_ff && code_ff != '0) begin
                     done_in   = 1'b1;
                     rx_pos_in = '0;
                     status_in = mrfe_pkg::ST_VALID;
                  end else begin
                     do_fail  = 1'b1;
                     fail_why = mrfe_pkg::ST_CRCBAD;
                  end
               end
            end
            mrfe_pkg::CMD_TIMEOUT: begin
               if (!done_ff) begin
                  do_fail  = 1'b1;
                  fail_why = mrfe_pkg::ST_TIMEOUT;
               end
            end
            default: begin
               status_in = mrfe_pkg::ST_ERROR;
            end
         endcase

         // failed attempt: count it, rearm transmit and receive
         if (do_fail) begin
            if (retries_ff != mrfe_pkg::RETRY_MAX) begin
               retries_in = retries_ff + RW'(1);
            end
            tx_pos_in = '0;
            tx_crc_in = '0;
            rx_pos_in = '0;
            rx_crc_in = '0;
            rx_low_in = '0;
            if (give_up) begin
               done_in   = 1'b1;
               status_in = mrfe_pkg::ST_GAVEUP;
            end else begin
               status_in = fail_why;
            end
         end
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // read ahead at the next transmit position, so data is ready when the pull arrives
   assign ram_rd_addr = PAY_AW'(tx_pos_in - HDR);
   assign ram_wr_addr = PAY_AW'(pcnt_ff);
   assign ram_wr_data = stage.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         reader_id_ff   <= mrfe_pkg::READER_ID_RST;
         retry_limit_ff <= mrfe_pkg::RETRY_LIMIT_RST;
         pcnt_ff        <= '0;
         tx_crc_ff      <= '0;
         tx_pos_ff      <= '0;
         rx_crc_ff      <= '0;
         rx_pos_ff      <= '0;
         rx_low_ff      <= '0;
         retries_ff     <= '0;
         done_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (mrfe_pkg::csr_type'(csr_index))
               mrfe_pkg::CSR_READER_ID: begin
                  reader_id_ff <= csr_wdata[mrfe_pkg::ID_W-1:0];
               end
               mrfe_pkg::CSR_RETRY_LIMIT: begin
                  retry_limit_ff <= csr_wdata[RW-1:0];
               end
            endcase
         end
         pcnt_ff      <= pcnt_in;
         tx_crc_ff    <= tx_crc_in;
         tx_pos_ff    <= tx_pos_in;
         rx_crc_ff    <= rx_crc_in;
         rx_pos_ff    <= rx_pos_in;
         rx_low_ff    <= rx_low_in;
         retries_ff   <= retries_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff   <= code_in;
      hdr_id_ff <= hdr_id_in;
      if (advance) begin
         status_ff      <= status_in;
         tx_byte_ff     <= tx_byte_in;
         tx_last_ff     <= tx_last_in;
         retry_count_ff <= retries_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.tx_byte     = tx_byte_ff;
   assign rsp.tx_last     = tx_last_ff;
   assign rsp.retry_count = retry_count_ff;

endmodule
`default_nettype wire

/* hdl/meter_reader_frame_engine.sv */
`default_nettype none
// channel  | direction | handshake             | payload
// req_ch   | in        | valid/ready           | cmd, data_byte
// rsp_ch   | out       | valid/ready           | status, tx_byte, tx_last, retry_count
// csr_*    | in        | csr_we, no back-press | csr_index, csr_wdata
//
// One request per clock while rsp_ch is not stalled; each result passes through the input
// register, then the result register after the CRC byte update.
// Synchronous reset clears all control state; the payload RAM is not cleared, bytes past
// the payload fill count read as zero, so no clearing pass is needed.
// A stalled result holds the result register; the input register holds at most one more
// request behind it, and req_ch.ready stays low while that register is full.
module meter_reader_frame_engine #(
   parameter int REQUEST_LEN  = mrfe_pkg::REQUEST_LEN_DEF,
   parameter int RESPONSE_LEN = mrfe_pkg::RESPONSE_LEN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [mrfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mrfe_pkg::CSR_DATA_W-1:0] csr_wdata,
   mrfe_req_if.sink                             req_ch,
   mrfe_rsp_if.source                           rsp_ch
);

   localparam int PAY_DEPTH = REQUEST_LEN - mrfe_pkg::HDR_LEN;
   localparam int PAY_AW    = $clog2(PAY_DEPTH);

   mrfe_pkg::req_stage_type     stage;
   logic                        advance;
   logic                        ram_wr_en;
   logic [PAY_AW-1:0]           ram_wr_addr;
   logic [mrfe_pkg::BYTE_W-1:0] ram_wr_data;
   logic [PAY_AW-1:0]           ram_rd_addr;
   logic [mrfe_pkg::BYTE_W-1:0] ram_rd_data;

   mrfe_req_stage u_req_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .advance (advance),
      .stage   (stage)
   );

   mrfe_payload_ram #(
      .DEPTH (PAY_DEPTH),
      .AW    (PAY_AW)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mrfe_core #(
      .REQUEST_LEN  (REQUEST_LEN),
      .RESPONSE_LEN (RESPONSE_LEN)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .stage       (stage),
      .advance     (advance),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp_ch)
   );

endmodule
`default_nettype wire

/* hdl/mrfe_checker.sv */
`default_nettype none
module mrfe_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [mrfe_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [mrfe_pkg::BYTE_W-1:0]    rsp_tx_byte,
   input wire logic                           rsp_tx_last,
   input wire logic [mrfe_pkg::RETRY_W-1:0]   rsp_retry_count
);

   // a stalled result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_tx_byte)
         && $stable(rsp_tx_last) && $stable(rsp_retry_count))
      else $error("result changed while stalled");

   // last-byte flag only on a transmit byte
   a_last_is_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_last |-> rsp_status == mrfe_pkg::ST_TX)
      else $error("tx_last without tx byte");

   // non-transmit results carry an empty byte
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mrfe_pkg::ST_TX |-> rsp_tx_byte == '0)
      else $error("tx_byte set on non-transmit result");

   // giving up always follows at least one counted failure
   a_gaveup_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrfe_pkg::ST_GAVEUP |-> rsp_retry_count != '0)
      else $error("give-up with zero retry count");

endmodule

bind meter_reader_frame_engine mrfe_checker u_mrfe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_tx_byte     (rsp_ch.tx_byte),
   .rsp_tx_last     (rsp_ch.tx_last),
   .rsp_retry_count (rsp_ch.retry_count)
);
`default_nettype wire

/* tb/testbench.sv */
module testbench;
   import mrfe_pkg::*;

   localparam int RANDOM_ITEMS = 750;
   localparam int PHASE_ITEMS  = 120;
   localparam int FRAME_TX_LEN = REQUEST_LEN_DEF + 2;
   localparam int PAYLOAD_MAX  = REQUEST_LEN_DEF - HDR_LEN;

   // cmd codes the block does not define
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_last;
      logic [RETRY_W-1:0] retry_count;
   } reply_type;

   class exchange_tracker;
      logic [ID_W-1:0]    reader_id;
      logic [RETRY_W-1:0] retry_limit;
      logic [BYTE_W-1:0]  frame [REQUEST_LEN_DEF];
      int unsigned        payload_count;
      int unsigned        tx_pos;
      int unsigned        rx_pos;
      logic [CRC_W-1:0]   tx_crc;
      logic [CRC_W-1:0]   rx_crc;
      logic [BYTE_W-1:0]  rx_crc_low;
      logic [RETRY_W-1:0] retries;
      bit                 done;
      reply_type          pending_replies [$];
      int                 mismatch_count;

      function new();
         reader_id = READER_ID_RST;
         retry_limit = RETRY_LIMIT_RST;
         foreach (frame[i]) frame[i] = '0;
         payload_count = 0;
         retries = '0;
         done = 1'b1;
         mismatch_count = 0;
         rearm();
      endfunction

      // CRC-16/ARC: reflected, bit-serial over one byte
      function logic [CRC_W-1:0] crc_update(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
         logic [CRC_W-1:0] c;
         c = crc ^ {8'h00, b};
         for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) c = (c >> 1) ^ 16'hA001;
            else c = c >> 1;
         end
         return c;
      endfunction

      function void rearm();
         tx_pos = 0;
         tx_crc = '0;
         rx_pos = 0;
         rx_crc = '0;
         rx_crc_low = '0;
      endfunction

      function status_type count_failure(status_type why);
         bit give_up;
         give_up = (retries >= retry_limit);
         if (retries != RETRY_MAX) retries++;
         rearm();
         if (give_up) begin
            done = 1'b1;
            return ST_GAVEUP;
         end
         return why;
      endfunction

      function void take_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] d);
         reply_type r;
         r.status = ST_ERROR;
         r.tx_byte = '0;
         r.tx_last = 1'b0;
         unique case (cmd)
            CMD_START: begin
               foreach (frame[i]) frame[i] = '0;
               frame[0] = d;
               frame[1] = reader_id[23:16];
               frame[2] = reader_id[15:8];
               frame[3] = reader_id[7:0];
               payload_count = 0;
               retries = '0;
               done = 1'b0;
               rearm();
               r.status = ST_ACCEPT;
            end
            CMD_PAYLOAD: begin
               // only before the first pull of the first attempt
               if (!done && tx_pos == 0 && retries == 0 && payload_count < PAYLOAD_MAX) begin
                  frame[HDR_LEN + payload_count] = d;
                  payload_count++;
                  r.status = ST_ACCEPT;
               end
            end
            CMD_PULL: begin
               if (!done && tx_pos < FRAME_TX_LEN) begin
                  if (tx_pos < REQUEST_LEN_DEF) begin
                     r.tx_byte = frame[tx_pos];
                     tx_crc = crc_update(tx_crc, r.tx_byte);
                  end else if (tx_pos == REQUEST_LEN_DEF) begin
                     r.tx_byte = tx_crc[7:0];
                  end else begin
                     r.tx_byte = tx_crc[15:8];
                     r.tx_last = 1'b1;
                  end
                  tx_pos++;
                  r.status = ST_TX;
               end
            end
            CMD_RESP: begin
               if (!done && tx_pos == FRAME_TX_LEN) begin
                  if (rx_pos < RESPONSE_LEN_DEF) begin
                     rx_crc = crc_update(rx_crc, d);
                     rx_pos++;
                     r.status = ST_ACCEPT;
                  end else if (rx_pos == RESPONSE_LEN_DEF) begin
                     rx_crc_low = d;
                     rx_pos++;
                     r.status = ST_ACCEPT;
                  end else if ({d, rx_crc_low} == rx_crc && frame[0] != 8'h00) begin
                     done = 1'b1;
                     rx_pos = 0;
                     r.status = ST_VALID;
                  end else begin
                     // a zero command code never validates
                     r.status = count_failure(ST_CRCBAD);
                  end
               end
            end
            CMD_TIMEOUT: begin
               if (!done) r.status = count_failure(ST_TIMEOUT);
            end
            default: ;
         endcase
         r.retry_count = retries;
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
         if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void match_reply(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] tx_byte,
                                logic tx_last, logic [RETRY_W-1:0] retry_count);
         reply_type want;
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no reply, got status %0d tx_byte %0d tx_last %0d retries %0d",
                     $time, status, tx_byte, tx_last, retry_count);
         end else begin
            want = pending_replies.pop_front();
            compare_field("status", BYTE_W'(want.status), BYTE_W'(status));
            compare_field("tx_byte", want.tx_byte, tx_byte);
            compare_field("tx_last", BYTE_W'(want.tx_last), BYTE_W'(tx_last));
            compare_field("retry_count", BYTE_W'(want.retry_count), BYTE_W'(retry_count));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mrfe_req_if req_if();
   mrfe_rsp_if rsp_if();

   exchange_tracker tracker = new();

   int send_idle_pct = 38;
   int recv_idle_pct = 86;
   int random_count = 0;
   logic [RETRY_W-1:0] retry_cap = RETRY_LIMIT_RST;

   meter_reader_frame_engine dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            tracker.match_reply(rsp_if.status, rsp_if.tx_byte, rsp_if.tx_last,
                                rsp_if.retry_count);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // called just after a rising edge; returns at the edge that takes the request
   task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.data_byte <= d;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.take_request(cmd, d);
   endtask

   // occasional stray request ahead of the real one
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] d);
      logic [CMD_W-1:0] stray;
      if ($urandom_range(49) == 0) begin
         stray = $urandom_range(1) ? CMD_PAYLOAD
                                   : CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
         send_req(stray, BYTE_W'($urandom_range(255)));
      end
      send_req(cmd, d);
      random_count++;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [ID_W-1:0] id, input logic [RETRY_W-1:0] limit);
      csr_we <= 1'b1;
      csr_index <= CSR_READER_ID;
      csr_wdata <= id;
      @(posedge clock);
      csr_index <= CSR_RETRY_LIMIT;
      csr_wdata <= {{(CSR_DATA_W-RETRY_W){1'b0}}, limit};
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.reader_id = id;
      tracker.retry_limit = limit;
      retry_cap = limit;
   endtask

   function automatic int pick_payload_count();
      return ($urandom_range(3) == 0) ? int'($urandom_range(PAYLOAD_MAX - 5, PAYLOAD_MAX + 2))
                                      : int'($urandom_range(0, 6));
   endfunction

   // whole frame out, whole response back
   task automatic run_full(input bit zero_code, input bit good_crc);
      logic [CRC_W-1:0]  crc;
      logic [BYTE_W-1:0] b;
      send_item(CMD_START, zero_code ? 8'h00 : 8'($urandom_range(1, 255)));
      repeat (pick_payload_count()) send_item(CMD_PAYLOAD, BYTE_W'($urandom_range(255)));
      repeat (FRAME_TX_LEN + ($urandom_range(3) == 0))
         send_item(CMD_PULL, BYTE_W'($urandom_range(255)));
      crc = '0;
      repeat (RESPONSE_LEN_DEF) begin
         b = BYTE_W'($urandom_range(255));
         crc = tracker.crc_update(crc, b);
         send_item(CMD_RESP, b);
      end
      if (!good_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
      send_item(CMD_RESP, crc[7:0]);
      send_item(CMD_RESP, crc[15:8]);
   endtask

   // partial frame, stray responses, then timeouts, usually up to give-up
   task automatic run_short();
      int n_fail;
      send_item(CMD_START, BYTE_W'($urandom_range(255)));
      repeat (pick_payload_count()) send_item(CMD_PAYLOAD, BYTE_W'($urandom_range(255)));
      repeat ($urandom_range(1) ? $urandom_range(0, 4) : $urandom_range(60, FRAME_TX_LEN + 2))
         send_item(CMD_PULL, BYTE_W'($urandom_range(255)));
      repeat ($urandom_range(3)) send_item(CMD_RESP, BYTE_W'($urandom_range(255)));
      n_fail = $urandom_range(1) ? int'(retry_cap) + 1 : int'($urandom_range(retry_cap));
      n_fail += int'($urandom_range(1));
      repeat (n_fail) begin
         repeat ($urandom_range(2)) send_item(CMD_PULL, BYTE_W'($urandom_range(255)));
         send_item(CMD_TIMEOUT, BYTE_W'($urandom_range(255)));
      end
   endtask

   initial begin
      int phase;
      int next_phase_at;
      int exchange_no;
      req_if.valid = 1'b0;
      req_if.cmd = CMD_START;
      req_if.data_byte = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle block answers error to everything but a start
      send_req(CMD_PAYLOAD, 8'hFF);
      send_req(CMD_PULL, 8'h00);
      send_req(CMD_RESP, 8'hA5);
      send_req(CMD_TIMEOUT, 8'h00);
      send_req(CMD_UNUSED_LO, 8'h00);
      send_req(CMD_UNUSED_LO + 3'd1, 8'h5A);
      send_req(CMD_UNUSED_HI, 8'hFF);
      send_req(CMD_START, 8'hFF);
      send_req(CMD_PAYLOAD, 8'h00);
      send_req(CMD_PAYLOAD, 8'hFF);
      send_req(CMD_RESP, 8'h12);
      send_req(CMD_PULL, 8'h00);
      send_req(CMD_PULL, 8'hFF);
      send_req(CMD_PAYLOAD, 8'h33);
      send_req(CMD_TIMEOUT, 8'hFF);
      send_req(CMD_PAYLOAD, 8'h44);
      send_req(CMD_UNUSED_HI, 8'h01);
      send_req(CMD_START, 8'h00);
      send_req(CMD_PAYLOAD, 8'h80);
      send_req(CMD_PULL, 8'h01);
      send_req(CMD_TIMEOUT, 8'h7F);
      send_req(CMD_START, 8'h01);

      phase = 0;
      next_phase_at = PHASE_ITEMS;
      exchange_no = 0;
      while (random_count < RANDOM_ITEMS) begin
         if (random_count >= next_phase_at) begin
            phase++;
            next_phase_at = random_count + PHASE_ITEMS;
            wait_idle();
            unique case (phase)
               1: write_regs('0, '0);
               2: write_regs('1, RETRY_MAX);
               3: write_regs(ID_W'($urandom_range(24'hFFFFFF)), RETRY_W'($urandom_range(1, 3)));
               default: write_regs(ID_W'($urandom_range(24'hFFFFFF)),
                                   RETRY_W'($urandom_range(0, 8)));
            endcase
         end
         if (random_count < 250) begin
            send_idle_pct = 38;
            recv_idle_pct = 86;
         end else if (random_count < 500) begin
            send_idle_pct = 86;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (exchange_no == 1) run_full(1'b1, 1'b1);
         else if (exchange_no == 3) run_full(1'b0, 1'b1);
         else if ($urandom_range(99) < 25) run_full($urandom_range(9) == 0, $urandom_range(3) != 0);
         else run_short();
         exchange_no++;
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.pending_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* meter_reader_frame_engine.f */
hdl/mrfe_pkg.sv
hdl/mrfe_if.sv
hdl/mrfe_payload_ram.sv
hdl/mrfe_req_stage.sv
hdl/mrfe_core.sv
hdl/meter_reader_frame_engine.sv
hdl/mrfe_checker.sv
tb/testbench.sv
